// ===== hdl/cit_pkg.sv =====
// Shared types, sizes and helpers for the counted item table.
package cit_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int CODE_BITS   = 8;
    localparam int COUNT_BITS  = 16;
    localparam int USED_BITS   = $clog2(MAX_ENTRIES + 1);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef enum logic
    {
        OP_ADD    = 1'b0,
        OP_REMOVE = 1'b1
    } op_t;

    typedef enum logic [2:0]
    {
        ST_APPENDED    = 3'd0,
        ST_INCREMENTED = 3'd1,
        ST_FULL        = 3'd2,
        ST_SATURATED   = 3'd3,
        ST_DECREMENTED = 3'd4,
        ST_DELETED     = 3'd5,
        ST_EMPTY       = 3'd6,
        ST_NOT_FOUND   = 3'd7
    } status_t;

    typedef struct packed
    {
        op_t                  op;
        logic [CODE_BITS-1:0] code;
    } cit_req_t;

    function automatic logic [CODE_BITS-1:0] to_code(input logic [7:0] c);
        logic [CODE_BITS+7:0] w;
        begin
            w = {{CODE_BITS{1'b0}}, c};
            return w[CODE_BITS-1:0];
        end
    endfunction

    function automatic logic [15:0] to_qty(input logic [COUNT_BITS-1:0] q);
        logic [COUNT_BITS+15:0] w;
        begin
            w = {{16{1'b0}}, q};
            return w[15:0];
        end
    endfunction

    function automatic logic [4:0] to_ecount(input logic [USED_BITS-1:0] u);
        logic [USED_BITS+4:0] w;
        begin
            w = {{5{1'b0}}, u};
            return w[4:0];
        end
    endfunction

endpackage

// ===== hdl/cit_front.sv =====
// Front end: accepts items, decodes the operation and queues them for the table.
module cit_front
    import cit_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  logic           mode,
    input  logic [7:0]     item_code,
    output logic           req_valid,
    output cit_req_t       req,
    input  logic           req_pop
);

    cit_req_t   slot0_reg;
    cit_req_t   slot1_reg;
    logic [1:0] count_reg;
    cit_req_t   incoming;
    logic       push;

    always_comb
    begin
        incoming.op   = mode ? OP_REMOVE : OP_ADD;
        incoming.code = to_code(item_code);
    end

    assign in_stall  = (count_reg == 2'd2);
    assign push      = in_valid && !in_stall;
    assign req_valid = (count_reg != 2'd0);
    assign req       = slot0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            case ({push, req_pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case ({push, req_pop})
            2'b10:
            begin
                if (count_reg == 2'd0)
                begin
                    slot0_reg <= incoming;
                end
                else
                begin
                    slot1_reg <= incoming;
                end
            end
            2'b01:
            begin
                slot0_reg <= slot1_reg;
            end
            2'b11:
            begin
                // push with pop only happens with one item held
                slot0_reg <= incoming;
            end
            default:
            begin
                slot0_reg <= slot0_reg;
            end
        endcase
    end

endmodule

// ===== hdl/cit_back.sv =====
// Back end: table cells with parallel match, update and shift, and the result register.
module cit_back
    import cit_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    input  cit_req_t    req,
    output logic        req_pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [15:0] quantity,
    output logic [4:0]  entry_count
);

    typedef enum logic [1:0]
    {
        S_MATCH = 2'b01,
        S_APPLY = 2'b10
    } state_t;

    state_t                state_reg;
    logic [USED_BITS-1:0]  used_reg;
    logic [USED_BITS-1:0]  used_next;
    logic [CODE_BITS-1:0]  code_cell_reg  [MAX_ENTRIES];
    logic [COUNT_BITS-1:0] count_cell_reg [MAX_ENTRIES];
    op_t                   op_reg;
    logic [CODE_BITS-1:0]  code_reg;
    logic [MAX_ENTRIES-1:0] hit_reg;
    logic [MAX_ENTRIES-1:0] ge_reg;
    logic [MAX_ENTRIES-1:0] hit_now;
    logic [MAX_ENTRIES-1:0] ge_now;

    logic                  out_valid_reg;
    status_t               status_reg;
    status_t               status_next;
    logic [COUNT_BITS-1:0] qty_reg;
    logic [COUNT_BITS-1:0] qty_next;
    logic [USED_BITS-1:0]  ecount_reg;

    logic                  found;
    logic                  full;
    logic [COUNT_BITS-1:0] hit_cnt;
    logic                  fire;
    logic                  do_app;
    logic                  do_inc;
    logic                  do_dec;
    logic                  do_del;

    // Match the queue head against every held cell at once
    always_comb
    begin
        logic [MAX_ENTRIES-1:0] mask;
        for (int k = 0; k < MAX_ENTRIES; k++)
        begin
            hit_now[k] = (USED_BITS'(k) < used_reg) && (code_cell_reg[k] == req.code);
        end
        for (int k = 0; k < MAX_ENTRIES; k++)
        begin
            mask = '0;
            for (int j = 0; j <= k; j++)
            begin
                mask[j] = 1'b1;
            end
            ge_now[k] = |(hit_now & mask);
        end
    end

    assign req_pop = (state_reg == S_MATCH) && req_valid;
    assign fire    = (state_reg == S_APPLY) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        hit_cnt = '0;
        for (int k = 0; k < MAX_ENTRIES; k++)
        begin
            hit_cnt = hit_cnt | (hit_reg[k] ? count_cell_reg[k] : '0);
        end
    end

    assign found = |hit_reg;
    assign full  = (used_reg == USED_BITS'(MAX_ENTRIES));

    always_comb
    begin
        status_next = ST_NOT_FOUND;
        qty_next    = '0;
        used_next   = used_reg;
        do_app      = 1'b0;
        do_inc      = 1'b0;
        do_dec      = 1'b0;
        do_del      = 1'b0;
        case (op_reg)
            OP_ADD:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                    qty_next    = found ? hit_cnt : '0;
                end
                else if (found)
                begin
                    if (hit_cnt == COUNT_MAX)
                    begin
                        status_next = ST_SATURATED;
                        qty_next    = COUNT_MAX;
                    end
                    else
                    begin
                        status_next = ST_INCREMENTED;
                        qty_next    = hit_cnt + COUNT_BITS'(1);
                        do_inc      = 1'b1;
                    end
                end
                else
                begin
                    status_next = ST_APPENDED;
                    qty_next    = COUNT_BITS'(1);
                    used_next   = used_reg + USED_BITS'(1);
                    do_app      = 1'b1;
                end
            end
            OP_REMOVE:
            begin
                if (used_reg == '0)
                begin
                    status_next = ST_EMPTY;
                end
                else if (!found)
                begin
                    status_next = ST_NOT_FOUND;
                end
                else if (hit_cnt > COUNT_BITS'(1))
                begin
                    status_next = ST_DECREMENTED;
                    qty_next    = hit_cnt - COUNT_BITS'(1);
                    do_dec      = 1'b1;
                end
                else
                begin
                    status_next = ST_DELETED;
                    used_next   = used_reg - USED_BITS'(1);
                    do_del      = 1'b1;
                end
            end
            default:
            begin
                status_next = ST_NOT_FOUND;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_MATCH;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_MATCH:
                begin
                    if (req_valid)
                    begin
                        state_reg <= S_APPLY;
                    end
                end
                S_APPLY:
                begin
                    if (fire)
                    begin
                        state_reg <= S_MATCH;
                    end
                end
                default:
                begin
                    state_reg <= S_MATCH;
                end
            endcase
            if (fire)
            begin
                used_reg <= used_next;
            end
            out_valid_reg <= fire || (out_valid_reg && out_stall);
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_pop)
        begin
            op_reg   <= req.op;
            code_reg <= req.code;
            hit_reg  <= hit_now;
            ge_reg   <= ge_now;
        end
        if (fire)
        begin
            status_reg <= status_next;
            qty_reg    <= qty_next;
            ecount_reg <= used_next;
        end
    end

    // Cells: append at the tail, count up or down in place, shift down on delete
    for (genvar g = 0; g < MAX_ENTRIES; g++)
    begin : g_cell
        logic [CODE_BITS-1:0]  code_above;
        logic [COUNT_BITS-1:0] count_above;

        if (g < MAX_ENTRIES - 1)
        begin : g_above
            assign code_above  = code_cell_reg[g+1];
            assign count_above = count_cell_reg[g+1];
        end
        else
        begin : g_top
            assign code_above  = code_cell_reg[g];
            assign count_above = count_cell_reg[g];
        end

        always_ff @(posedge clk)
        begin
            if (fire)
            begin
                if (do_app && (USED_BITS'(g) == used_reg))
                begin
                    code_cell_reg[g]  <= code_reg;
                    count_cell_reg[g] <= COUNT_BITS'(1);
                end
                else if (do_inc && hit_reg[g])
                begin
                    count_cell_reg[g] <= count_cell_reg[g] + COUNT_BITS'(1);
                end
                else if (do_dec && hit_reg[g])
                begin
                    count_cell_reg[g] <= count_cell_reg[g] - COUNT_BITS'(1);
                end
                else if (do_del && ge_reg[g])
                begin
                    code_cell_reg[g]  <= code_above;
                    count_cell_reg[g] <= count_above;
                end
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign quantity    = to_qty(qty_reg);
    assign entry_count = to_ecount(ecount_reg);

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= USED_BITS'(MAX_ENTRIES))
        else $error("entry count beyond table size");

    a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_APPLY) |-> $onehot0(hit_reg))
        else $error("code matched in more than one cell");

    a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && do_app) |=> (used_reg == $past(used_reg) + USED_BITS'(1)))
        else $error("append did not grow the table");

    a_delete_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && do_del) |=> (used_reg == $past(used_reg) - USED_BITS'(1)))
        else $error("delete did not shrink the table");

endmodule

// ===== hdl/counted_item_table_unit.sv =====
// Top level of the counted item table: front queue feeding the table back end.
//
//   channel | valid     | stall     | fields
//   --------+-----------+-----------+-------------------------------
//   input   | in_valid  | in_stall  | mode, item_code
//   output  | out_valid | out_stall | status, quantity, entry_count
//
// In the back end, S_MATCH compares each item's code against every cell, then
// S_APPLY updates the cells and loads the result register.
// A two-item queue in front keeps taking items while a result waits.
// Reset clears the entry count and all valid flags; cell contents stay as they are.
// A stalled result holds the back end; the queue fills, then in_stall rises.
module counted_item_table_unit
    import cit_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        mode,
    input  logic [7:0]  item_code,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [15:0] quantity,
    output logic [4:0]  entry_count
);

    logic     req_valid;
    cit_req_t req;
    logic     req_pop;

    cit_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .item_code (item_code),
        .req_valid (req_valid),
        .req       (req),
        .req_pop   (req_pop)
    );

    cit_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req         (req),
        .req_pop     (req_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .quantity    (quantity),
        .entry_count (entry_count)
    );

endmodule
